### rtl/sbox_stream_byte_decryptor_core_defines.svh
// Assertion macros shared by the decryptor RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SBOX_STREAM_BYTE_DECRYPTOR_CORE_DEFINES_SVH
`define SBOX_STREAM_BYTE_DECRYPTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SBSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbsd assertion failed");

// Next-cycle implication, disabled during reset
`define SBSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbsd assertion failed");

`endif

### rtl/sbsd_pkg.sv
// Types and constants of the substitution-table byte decryptor.
// No dependencies; imported by the core.
package sbsd_pkg;

    localparam int unsigned DATA_W        = 8;
    localparam int unsigned TABLE_DEPTH   = 256;
    localparam int unsigned TABLE_ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int unsigned APB_ADDR_W    = 3;
    localparam int unsigned APB_DATA_W    = 32;

    localparam logic [DATA_W-1:0] SEED_FIRST    = 8'd8;
    localparam logic [DATA_W-1:0] PAYLOAD_FIRST = 8'd24;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_DATA = 1'b1
    } cmd_t;

    // Register word index (paddr[2])
    typedef enum logic {
        REG_DECRYPT_ENABLE = 1'b0,
        REG_UNMAPPED       = 1'b1
    } reg_idx_t;

    typedef logic [DATA_W-1:0] byte_t;

    // Offsets added to the table output during the 16 seed steps
    function automatic byte_t seed_add(input logic [3:0] k);
        byte_t v;
        unique case (k)
            4'd0:    v = 8'd141;
            4'd1:    v = 8'd34;
            4'd2:    v = 8'd182;
            4'd3:    v = 8'd161;
            4'd4:    v = 8'd59;
            4'd5:    v = 8'd244;
            4'd6:    v = 8'd212;
            4'd7:    v = 8'd145;
            4'd8:    v = 8'd149;
            4'd9:    v = 8'd42;
            4'd10:   v = 8'd190;
            4'd11:   v = 8'd169;
            4'd12:   v = 8'd67;
            4'd13:   v = 8'd252;
            4'd14:   v = 8'd220;
            default: v = 8'd137;
        endcase
        return v;
    endfunction

    // Offsets added to each payload output, chosen by position mod 8
    function automatic byte_t step_add(input logic [2:0] k);
        byte_t v;
        unique case (k)
            3'd0:    v = 8'd140;
            3'd1:    v = 8'd32;
            3'd2:    v = 8'd179;
            3'd3:    v = 8'd157;
            3'd4:    v = 8'd54;
            3'd5:    v = 8'd238;
            3'd6:    v = 8'd205;
            default: v = 8'd137;
        endcase
        return v;
    endfunction

endpackage

### rtl/sbox_stream_byte_decryptor_core.sv
// Substitution-table byte-stream decryptor, single module.
// Depends on sbsd_pkg and sbox_stream_byte_decryptor_core_defines.svh.
//
// Usage: load the 256-entry table with load beats (command = 0), then set
// decrypt_enable over APB and stream blob bytes (command = 1). A load beat and
// a byte that bypasses the table (header bytes, or any byte while decryption
// is off) are handled when accepted. A byte that goes through the table (seed
// bytes 8..23 and payload bytes) blocks the input until its RAM output is
// folded into the state, as its address depends on the previous table output
// and the table is a synchronous RAM with a registered read port. A result is
// held in an output register; a new beat is taken when no table read is in
// flight and that register is empty or being drained. No clearing after reset.
module sbox_stream_byte_decryptor_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    // APB configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sbsd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sbsd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sbsd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    // input beats
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic                               command,
    input  logic [sbsd_pkg::TABLE_ADDR_W-1:0]  table_index,
    input  logic [sbsd_pkg::DATA_W-1:0]        table_value,
    input  logic [sbsd_pkg::DATA_W-1:0]        byte_in,
    input  logic                               last_byte,
    // result beats
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [sbsd_pkg::DATA_W-1:0]        byte_out,
    output logic                               is_header,
    output logic                               out_last
);
    import sbsd_pkg::*;

    `include "sbox_stream_byte_decryptor_core_defines.svh"

    // table RAM
    byte_t table_mem [TABLE_DEPTH];
    byte_t rdata_reg;

    // control and state
    logic  decrypt_enable_reg, decrypt_enable_next;
    byte_t state_reg, state_next;
    byte_t pos_reg, pos_next;
    logic  past_seed_reg, past_seed_next;
    logic  busy_reg, busy_next;
    logic  pend_seed_reg, pend_last_reg;
    byte_t add_reg;

    // output register
    logic  out_valid_reg, out_valid_next;
    byte_t out_byte_reg, out_byte_next;
    logic  out_header_reg, out_header_next;
    logic  out_last_reg, out_last_next;

    logic  accept, is_data, header, seed, use_table, cfg_write;
    logic  [3:0] seed_k;
    byte_t key, rd_addr, add_next, new_state, pos_inc;

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign prdata     = (reg_idx_t'(paddr[2]) == REG_DECRYPT_ENABLE)
                        ? {{(APB_DATA_W-1){1'b0}}, decrypt_enable_reg}
                        : '0;

    assign item_ready = !busy_reg && (!out_valid_reg || result_ready);
    assign accept     = item_valid && item_ready;
    assign is_data    = (command == CMD_DATA);
    assign header     = !past_seed_reg && (pos_reg < SEED_FIRST);
    assign seed       = !past_seed_reg && !header;
    assign use_table  = is_data && decrypt_enable_reg && !header;

    assign seed_k     = 4'(pos_reg - SEED_FIRST);
    assign key        = state_reg + pos_reg - SEED_FIRST;
    assign pos_inc    = pos_reg + 8'd1;
    assign new_state  = rdata_reg + add_reg;

    always_comb
    begin
        if (seed)
        begin
            // first seed step ignores the previous state
            rd_addr  = (seed_k == 4'd0) ? byte_in : (byte_in ^ state_reg);
            add_next = seed_add(seed_k);
        end
        else
        begin
            rd_addr  = byte_in ^ key;
            add_next = step_add(pos_reg[2:0]);
        end
    end

    always_comb
    begin
        decrypt_enable_next = decrypt_enable_reg;
        state_next          = state_reg;
        pos_next            = pos_reg;
        past_seed_next      = past_seed_reg;
        busy_next           = accept && use_table;
        out_valid_next      = out_valid_reg && !result_ready;
        out_byte_next       = out_byte_reg;
        out_header_next     = out_header_reg;
        out_last_next       = out_last_reg;

        if (cfg_write && reg_idx_t'(paddr[2]) == REG_DECRYPT_ENABLE)
        begin
            decrypt_enable_next = pwdata[0];
        end

        // table byte with its read done: fold the RAM output into the state
        if (busy_reg)
        begin
            state_next = pend_last_reg ? '0 : new_state;
            if (!pend_seed_reg)
            begin
                out_valid_next  = 1'b1;
                out_byte_next   = rdata_reg;
                out_header_next = 1'b0;
                out_last_next   = pend_last_reg;
            end
        end

        if (accept && is_data)
        begin
            if (!use_table)
            begin
                out_valid_next  = 1'b1;
                out_byte_next   = byte_in;
                out_header_next = header;
                out_last_next   = last_byte;
                if (last_byte)
                begin
                    state_next = '0;
                end
            end
            priority if (last_byte)
            begin
                pos_next       = '0;
                past_seed_next = 1'b0;
            end
            else if (!past_seed_reg)
            begin
                pos_next       = pos_inc;
                past_seed_next = (pos_inc >= PAYLOAD_FIRST);
            end
            else
            begin
                pos_next = pos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decrypt_enable_reg <= 1'b0;
            state_reg          <= '0;
            pos_reg            <= '0;
            past_seed_reg      <= 1'b0;
            busy_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            decrypt_enable_reg <= decrypt_enable_next;
            state_reg          <= state_next;
            pos_reg            <= pos_next;
            past_seed_reg      <= past_seed_next;
            busy_reg           <= busy_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        out_header_reg <= out_header_next;
        out_last_reg   <= out_last_next;
        if (accept && use_table)
        begin
            pend_seed_reg <= seed;
            pend_last_reg <= last_byte;
            add_reg       <= add_next;
        end
    end

    // table RAM: one write port for loads, one registered read port
    always_ff @(posedge clk)
    begin
        if (accept && !is_data)
        begin
            table_mem[table_index] <= table_value;
        end
        if (accept && use_table)
        begin
            rdata_reg <= table_mem[rd_addr];
        end
    end

    assign result_valid = out_valid_reg;
    assign byte_out     = out_byte_reg;
    assign is_header    = out_header_reg;
    assign out_last     = out_last_reg;

    // the state loop holds off input: no beat while a table read is in flight
    `SBSD_ASSERT_NOW(a_busy_blocks_input, clk, rst_n, busy_reg, !item_ready)
    `SBSD_ASSERT_NEXT(a_busy_single_cycle, clk, rst_n, busy_reg, !busy_reg)
    // output slot is reserved for the table result
    `SBSD_ASSERT_NOW(a_slot_free_when_busy, clk, rst_n, busy_reg, !out_valid_reg)
    `SBSD_ASSERT_NEXT(a_load_no_result, clk, rst_n,
                      accept && !is_data && !out_valid_reg, !out_valid_reg && !busy_reg)

endmodule

### sim/sbsd_checker.sv
`timescale 1ns / 100ps
// Result checker for the substitution-table byte decryptor: mirrors table, cipher
// state and position from the observed beats and compares every result beat.
// Depends on sbsd_pkg.
module sbsd_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sbsd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sbsd_pkg::APB_DATA_W-1:0]    pwdata,
    input  logic                               pready,
    input  logic                               item_valid,
    input  logic                               item_ready,
    input  logic                               command,
    input  logic [sbsd_pkg::TABLE_ADDR_W-1:0]  table_index,
    input  logic [sbsd_pkg::DATA_W-1:0]        table_value,
    input  logic [sbsd_pkg::DATA_W-1:0]        byte_in,
    input  logic                               last_byte,
    input  logic                               result_valid,
    input  logic                               result_ready,
    input  logic [sbsd_pkg::DATA_W-1:0]        byte_out,
    input  logic                               is_header,
    input  logic                               out_last,
    output int                                 mismatch_count,
    output int                                 pending
);
    import sbsd_pkg::*;

    // entry k sits at bits k*8 +: 8
    localparam logic [16*DATA_W-1:0] SEED_OFS = {
        8'd137, 8'd220, 8'd252, 8'd67, 8'd169, 8'd190, 8'd42, 8'd149,
        8'd145, 8'd212, 8'd244, 8'd59, 8'd161, 8'd182, 8'd34, 8'd141
    };
    localparam logic [8*DATA_W-1:0] STEP_OFS = {
        8'd137, 8'd205, 8'd238, 8'd54, 8'd157, 8'd179, 8'd32, 8'd140
    };

    typedef struct packed {
        byte_t value;
        logic  header;
        logic  last;
    } out_beat_t;

    out_beat_t expected_bytes[$];
    byte_t     sbox_copy [TABLE_DEPTH];
    byte_t     key_state;
    byte_t     pos_low;
    logic      seeded;
    logic      enable_copy;

    task automatic decrypt_beat();
        byte_t     pos;
        byte_t     res;
        byte_t     addr;
        byte_t     key;
        byte_t     seed_ofs;
        logic [3:0] k;
        logic      hdr;
        logic      in_seed;
        logic      emit;
        out_beat_t eb;
        pos     = pos_low;
        hdr     = !seeded && (pos < SEED_FIRST);
        in_seed = !seeded && (pos >= SEED_FIRST);
        if (cmd_t'(command) == CMD_LOAD)
        begin
            sbox_copy[table_index] = table_value;
            return;
        end
        emit = 1'b1;
        res  = byte_in;
        if (enable_copy && in_seed)
        begin
            seed_ofs  = pos - SEED_FIRST;
            k         = seed_ofs[3:0];
            // first seed step starts the chain from the raw byte
            addr      = (k == 4'd0) ? byte_in : (byte_in ^ key_state);
            key_state = sbox_copy[addr] + SEED_OFS[k*DATA_W +: DATA_W];
            emit      = 1'b0;
        end
        else if (enable_copy && seeded)
        begin
            key       = key_state + pos - SEED_FIRST;
            res       = sbox_copy[byte_in ^ key];
            key_state = res + STEP_OFS[pos[2:0]*DATA_W +: DATA_W];
        end
        if (emit)
        begin
            eb.value  = res;
            eb.header = hdr;
            eb.last   = last_byte;
            expected_bytes.push_back(eb);
        end
        if (last_byte)
        begin
            key_state = '0;
            pos_low   = '0;
            seeded    = 1'b0;
        end
        else
        begin
            pos_low = pos + 8'd1;
            if (!seeded && pos_low >= PAYLOAD_FIRST)
                seeded = 1'b1;
        end
    endtask

    task automatic check_result();
        out_beat_t want;
        if (expected_bytes.size() == 0)
        begin
            $error("result beat with nothing expected: byte_out %0h", byte_out);
            mismatch_count++;
            return;
        end
        want = expected_bytes.pop_front();
        if (byte_out !== want.value)
        begin
            $error("byte_out: expected %0h, got %0h", want.value, byte_out);
            mismatch_count++;
        end
        if (is_header !== want.header)
        begin
            $error("is_header: expected %0b, got %0b", want.header, is_header);
            mismatch_count++;
        end
        if (out_last !== want.last)
        begin
            $error("out_last: expected %0b, got %0b", want.last, out_last);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_state      = '0;
            pos_low        = '0;
            seeded         = 1'b0;
            enable_copy    = 1'b0;
            mismatch_count = 0;
            pending        = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && reg_idx_t'(paddr[2]) == REG_DECRYPT_ENABLE)
                enable_copy = pwdata[0];
            if (result_valid && result_ready)
                check_result();
            if (item_valid && item_ready)
                decrypt_beat();
            pending = expected_bytes.size();
        end
    end

endmodule

### sim/tb_sbox_stream_byte_decryptor_core.sv
`timescale 1ns / 100ps
// Testbench top for the substitution-table byte decryptor: clock, reset, APB
// writes, input beats, result back-pressure and the verdict.
// Depends on sbsd_pkg, sbox_stream_byte_decryptor_core and sbsd_checker.
module tb_sbox_stream_byte_decryptor_core;
    import sbsd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TOTAL_BEATS  = 1850;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 600;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    item_valid;
    logic                    item_ready;
    logic                    command;
    logic [TABLE_ADDR_W-1:0] table_index;
    byte_t                   table_value;
    byte_t                   byte_in;
    logic                    last_byte;
    logic                    result_valid;
    logic                    result_ready;
    byte_t                   byte_out;
    logic                    is_header;
    logic                    out_last;

    int   mismatch_count;
    int   pending;
    int   cycle_count = 0;
    int   beats_sent  = 0;
    int   burst_left  = 0;
    logic hold_req    = 1'b0;

    sbox_stream_byte_decryptor_core uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .command      (command),
        .table_index  (table_index),
        .table_value  (table_value),
        .byte_in      (byte_in),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .byte_out     (byte_out),
        .is_header    (is_header),
        .out_last     (out_last)
    );

    sbsd_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .command        (command),
        .table_index    (table_index),
        .table_value    (table_value),
        .byte_in        (byte_in),
        .last_byte      (last_byte),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .byte_out       (byte_out),
        .is_header      (is_header),
        .out_last       (out_last),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: a stall mix that is picked anew at random, one long hold-off
    initial
    begin
        int   stall_pct;
        int   mode_left;
        logic hold_done;
        stall_pct    = 0;
        mode_left    = 0;
        hold_done    = 1'b0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            result_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_beat(input cmd_t cmd, input byte_t idx, input byte_t val,
                             input byte_t b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        item_valid  <= 1'b1;
        command     <= cmd;
        table_index <= idx;
        table_value <= val;
        byte_in     <= b;
        last_byte   <= last;
        do @(posedge clk); while (!item_ready);
        beats_sent++;
    endtask

    task automatic send_load(input byte_t idx, input byte_t val);
        send_beat(CMD_LOAD, idx, val, byte_t'($urandom), ($urandom_range(0, 1) == 1));
    endtask

    task automatic send_byte(input byte_t b, input logic last);
        send_beat(CMD_DATA, byte_t'($urandom), byte_t'($urandom), b, last);
    endtask

    // len data beats, loads mixed in at load_pct; last beat ends the blob if terminate
    task automatic send_blob(input int len, input int load_pct, input logic terminate);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < load_pct)
                send_load(byte_t'($urandom), byte_t'($urandom));
            send_byte(byte_t'($urandom), terminate && (i == len - 1));
        end
    endtask

    // seed beats give no result, so wait on for DRAIN_CYCLES past the last result
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_enable(input logic en);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DECRYPT_ENABLE, 2'b00};
        pwdata  <= {{(APB_DATA_W-1){1'b0}}, en};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        int r;
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        item_valid  <= 1'b0;
        command     <= CMD_LOAD;
        table_index <= '0;
        table_value <= '0;
        byte_in     <= '0;
        last_byte   <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_enable(1'b0);
        // pass-through while the table is still empty
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        // every entry is written before decryption can read the table
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_load(byte_t'(i), byte_t'($urandom));
        send_load(8'd0, 8'hFF);
        send_load(8'd255, 8'h00);
        wait_idle();
        write_enable(1'b1);

        // header, full seed run and one payload byte; a load lands mid-seed
        for (int i = 0; i < 25; i++)
        begin
            if (i == 15)
                send_load(8'h80, 8'h7F);
            send_byte(i[0] ? 8'hFF : 8'h00, i == 24);
        end
        // blob ending inside the seed run: results for its header bytes only
        send_blob(10, 0, 1'b1);

        // long blob wraps the position while results back up
        hold_req <= 1'b1;
        send_blob($urandom_range(280, 320), 5, 1'b1);
        while (beats_sent < TOTAL_BEATS)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                wait_idle();
                write_enable($urandom_range(0, 3) != 0);
            end
            else if (r < 14)
            begin
                // stop mid-blob, set the enable at random, carry on with the same blob
                send_blob($urandom_range(1, 40), 5, 1'b0);
                wait_idle();
                write_enable($urandom_range(0, 1) == 1);
            end
            else if (r < 22)
                send_blob($urandom_range(1, 23), 5, 1'b1);
            else if (r < 25)
            begin
                repeat ($urandom_range(1, 6))
                    send_beat(cmd_t'($urandom_range(0, 1)), byte_t'($urandom),
                              byte_t'($urandom), byte_t'($urandom),
                              $urandom_range(0, 3) == 0);
            end
            else
                send_blob($urandom_range(25, 72), 5, 1'b1);
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/sbsd_pkg.sv
rtl/sbox_stream_byte_decryptor_core.sv
sim/sbsd_checker.sv
sim/tb_sbox_stream_byte_decryptor_core.sv
